/* rtl/core/sha224_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-224 shared definitions
// Round constants, initial hash values, round functions and the control
// bundle passed from the sequencer to the round datapath.
// ----------------------------------------------------------------------------
package sha224_pkg;

	localparam int unsigned BlkWords   = 16;
	localparam int unsigned ChainWords = 8;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned LenPos     = 56;
	localparam logic [7:0]  PadByte    = 8'h80;

	// Control for the round datapath.
	typedef struct packed {
		logic       shift;  // shift a word into the working variables
		logic       step;   // run one compression round
		logic       fresh;  // round takes its schedule word from the block memory
		logic [5:0] rnd;    // round number
	} sha224_ctrl_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Initial hash values for SHA-224.
	function automatic logic [31:0] iv_word(input logic [2:0] i);
		unique case (i)
			3'd0: iv_word = 32'hc1059ed8;
			3'd1: iv_word = 32'h367cd507;
			3'd2: iv_word = 32'h3070dd17;
			3'd3: iv_word = 32'hf70e5939;
			3'd4: iv_word = 32'hffc00b31;
			3'd5: iv_word = 32'h68581511;
			3'd6: iv_word = 32'h64f98fa7;
			default: iv_word = 32'hbefa4fa4;
		endcase
	endfunction

	// Round constants.
	function automatic logic [31:0] k_word(input logic [5:0] i);
		unique case (i)
			6'd0:  k_word = 32'h428a2f98; 6'd1:  k_word = 32'h71374491;
			6'd2:  k_word = 32'hb5c0fbcf; 6'd3:  k_word = 32'he9b5dba5;
			6'd4:  k_word = 32'h3956c25b; 6'd5:  k_word = 32'h59f111f1;
			6'd6:  k_word = 32'h923f82a4; 6'd7:  k_word = 32'hab1c5ed5;
			6'd8:  k_word = 32'hd807aa98; 6'd9:  k_word = 32'h12835b01;
			6'd10: k_word = 32'h243185be; 6'd11: k_word = 32'h550c7dc3;
			6'd12: k_word = 32'h72be5d74; 6'd13: k_word = 32'h80deb1fe;
			6'd14: k_word = 32'h9bdc06a7; 6'd15: k_word = 32'hc19bf174;
			6'd16: k_word = 32'he49b69c1; 6'd17: k_word = 32'hefbe4786;
			6'd18: k_word = 32'h0fc19dc6; 6'd19: k_word = 32'h240ca1cc;
			6'd20: k_word = 32'h2de92c6f; 6'd21: k_word = 32'h4a7484aa;
			6'd22: k_word = 32'h5cb0a9dc; 6'd23: k_word = 32'h76f988da;
			6'd24: k_word = 32'h983e5152; 6'd25: k_word = 32'ha831c66d;
			6'd26: k_word = 32'hb00327c8; 6'd27: k_word = 32'hbf597fc7;
			6'd28: k_word = 32'hc6e00bf3; 6'd29: k_word = 32'hd5a79147;
			6'd30: k_word = 32'h06ca6351; 6'd31: k_word = 32'h14292967;
			6'd32: k_word = 32'h27b70a85; 6'd33: k_word = 32'h2e1b2138;
			6'd34: k_word = 32'h4d2c6dfc; 6'd35: k_word = 32'h53380d13;
			6'd36: k_word = 32'h650a7354; 6'd37: k_word = 32'h766a0abb;
			6'd38: k_word = 32'h81c2c92e; 6'd39: k_word = 32'h92722c85;
			6'd40: k_word = 32'ha2bfe8a1; 6'd41: k_word = 32'ha81a664b;
			6'd42: k_word = 32'hc24b8b70; 6'd43: k_word = 32'hc76c51a3;
			6'd44: k_word = 32'hd192e819; 6'd45: k_word = 32'hd6990624;
			6'd46: k_word = 32'hf40e3585; 6'd47: k_word = 32'h106aa070;
			6'd48: k_word = 32'h19a4c116; 6'd49: k_word = 32'h1e376c08;
			6'd50: k_word = 32'h2748774c; 6'd51: k_word = 32'h34b0bcb5;
			6'd52: k_word = 32'h391c0cb3; 6'd53: k_word = 32'h4ed8aa4a;
			6'd54: k_word = 32'h5b9cca4f; 6'd55: k_word = 32'h682e6ff3;
			6'd56: k_word = 32'h748f82ee; 6'd57: k_word = 32'h78a5636f;
			6'd58: k_word = 32'h84c87814; 6'd59: k_word = 32'h8cc70208;
			6'd60: k_word = 32'h90befffa; 6'd61: k_word = 32'ha4506ceb;
			6'd62: k_word = 32'hbef9a3f7;
			default: k_word = 32'hc67178f2;
		endcase
	endfunction

endpackage
`default_nettype wire

/* rtl/core/sha224_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-224 round datapath
// Holds the working variables and the 16-word message schedule window and
// performs one compression round per step.
// ----------------------------------------------------------------------------
module sha224_core
	import sha224_pkg::*;
(
	input  wire logic         clk,
	input  wire sha224_ctrl_t ctrl,
	input  wire logic [31:0]  shift_word,
	input  wire logic [31:0]  blk_word,
	output logic      [31:0]  head_word
);

	logic [31:0] v_q [ChainWords];
	logic [31:0] s_q [BlkWords];
	logic [31:0] w, t1, t2;

	// Schedule word and round sums.
	always_comb begin
		if (ctrl.fresh) begin
			w = blk_word;
		end else begin
			w = ssig1(s_q[14]) + s_q[9] + ssig0(s_q[1]) + s_q[0];
		end
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ k_word(ctrl.rnd) + w;
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign head_word = v_q[0];

	// Working variables: shifted in from the chain memory, or advanced one round.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < ChainWords - 1; i++) begin
				v_q[i] <= v_q[i + 1];
			end
			v_q[ChainWords - 1] <= shift_word;
		end else if (ctrl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Schedule window: newest word at the top.
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			for (int i = 0; i < BlkWords - 1; i++) begin
				s_q[i] <= s_q[i + 1];
			end
			s_q[BlkWords - 1] <= w;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sha224_byte_stream_hasher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-224 byte stream hasher
// Gathers message bytes into 64-byte blocks, compresses them, pads the
// message on request and returns the seven-word digest.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one request per item:
// an optional byte (byte_present, data_byte) and an end_of_message flag.
// A plain byte is taken without leaving the idle state. The byte that
// completes a 64-byte block starts a compression: the chain value is loaded
// from its memory, 64 rounds run on the shared round unit, and the sums are
// written back. The input is not ready during that time, so the byte rate is
// set by the round loop and the word-at-a-time chain memory access.
// An end-of-message request writes the padding one byte per cycle into the
// block memory, then runs one or two compressions. The digest then leaves
// on the output channel (out_valid/out_ready) as seven words, H0 first,
// each read from the chain memory and registered before it is shown; the
// block holds the word until it is taken and accepts no new request.
// After reset, the initial hash values are written into the chain memory
// before the first request is accepted. Reset clears all control state.
// ----------------------------------------------------------------------------
module sha224_byte_stream_hasher
	import sha224_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] digest_word,
	output logic      [2:0]  word_index,
	output logic             last_word
);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_PAD    = 7'b0000100,
		ST_LOAD   = 7'b0001000,
		ST_ROUND  = 7'b0010000,
		ST_UPDATE = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t       state_q;
	logic [6:0]   cnt_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic         padding_q, pad_first_q, split_q, final_q, emit_rd_q;
	logic [31:0]  out_word_q;

	// Memories.
	logic [31:0]  blk_mem [BlkWords];
	logic [31:0]  chain_mem [ChainWords];
	logic [31:0]  blk_rd_q, chain_rd_q;

	logic         accept, blk_we, ch_we, split_now;
	logic [7:0]   blk_wbyte, pad_byte;
	logic [3:0]   blk_raddr;
	logic [2:0]   ch_raddr, ch_waddr;
	logic [31:0]  ch_wdata, head_word;
	logic [7:0]   len_shift;
	sha224_ctrl_t ctrl;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = (state_q == ST_EMIT) && !emit_rd_q && (cnt_q[6:3] == 4'd1);
	assign digest_word = out_word_q;
	assign word_index  = cnt_q[2:0];
	assign last_word   = (cnt_q[2:0] == 3'd6);

	// Padding byte for the current fill position.
	assign len_shift = 8'(bits_q >> {~fill_q[2:0], 3'b000});
	assign split_now = split_q || (pad_first_q && (fill_q >= 6'(LenPos)));
	always_comb begin
		if (pad_first_q) begin
			pad_byte = PadByte;
		end else if ((fill_q >= 6'(LenPos)) && !split_q) begin
			pad_byte = len_shift;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Block memory write and read address selection.
	always_comb begin
		blk_we    = (accept && byte_present) || (state_q == ST_PAD);
		blk_wbyte = (state_q == ST_PAD) ? pad_byte : data_byte;
		blk_raddr = (state_q == ST_ROUND) ? (cnt_q[3:0] + 4'd1) : 4'd0;
	end

	// Chain memory access selection.
	always_comb begin
		ch_we    = 1'b0;
		ch_waddr = cnt_q[2:0];
		ch_wdata = iv_word(cnt_q[2:0]);
		ch_raddr = cnt_q[2:0];
		unique case (state_q)
			ST_INIT: begin
				ch_we = 1'b1;
			end
			ST_UPDATE: begin
				ch_we    = (cnt_q != 7'd0);
				ch_waddr = cnt_q[2:0] - 3'd1;
				ch_wdata = chain_rd_q + head_word;
			end
			ST_EMIT: begin
				// Reload the initial value once the word has been read out.
				ch_we = emit_rd_q || (out_valid && out_ready && last_word);
				ch_waddr = emit_rd_q ? cnt_q[2:0] : 3'd7;
				ch_wdata = iv_word(ch_waddr);
			end
			default: begin
				ch_we = 1'b0;
			end
		endcase
	end

	// Round datapath control.
	always_comb begin
		ctrl.shift = ((state_q == ST_LOAD) || (state_q == ST_UPDATE)) && (cnt_q != 7'd0);
		ctrl.step  = (state_q == ST_ROUND);
		ctrl.fresh = (cnt_q[6:4] == 3'd0);
		ctrl.rnd   = cnt_q[5:0];
	end

	// Block memory with byte lanes, big-endian within each word.
	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[fill_q[5:2]][8 * (3 - fill_q[1:0]) +: 8] <= blk_wbyte;
		end
		blk_rd_q <= blk_mem[blk_raddr];
	end

	// Chain value memory.
	always_ff @(posedge clk) begin
		if (ch_we) begin
			chain_mem[ch_waddr] <= ch_wdata;
		end
		chain_rd_q <= chain_mem[ch_raddr];
	end

	// Captured digest word.
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && emit_rd_q) begin
			out_word_q <= chain_rd_q;
		end
	end

	sha224_core u_core (
		.clk        (clk),
		.ctrl       (ctrl),
		.shift_word (chain_rd_q),
		.blk_word   (blk_rd_q),
		.head_word  (head_word)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			fill_q      <= '0;
			bits_q      <= '0;
			padding_q   <= 1'b0;
			pad_first_q <= 1'b0;
			split_q     <= 1'b0;
			final_q     <= 1'b0;
			emit_rd_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd7) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (end_of_message) begin
							padding_q   <= 1'b1;
							pad_first_q <= 1'b1;
						end
						if (byte_present && (fill_q == 6'd63)) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q      <= fill_q + 6'd1;
					pad_first_q <= 1'b0;
					split_q     <= split_now;
					if (fill_q == 6'd63) begin
						split_q <= 1'b0;
						final_q <= !split_now;
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd8) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(Rounds - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd8) begin
						cnt_q <= '0;
						if (final_q) begin
							emit_rd_q <= 1'b0;
							state_q   <= ST_EMIT;
						end else if (padding_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					// cnt_q[6:3] marks the phase: 0 issue read, 1 word shown.
					if (cnt_q[6:3] == 4'd0) begin
						emit_rd_q <= 1'b1;
						cnt_q     <= {4'd1, cnt_q[2:0]};
					end else if (emit_rd_q) begin
						emit_rd_q <= 1'b0;
					end else if (out_ready) begin
						if (last_word) begin
							cnt_q     <= '0;
							fill_q    <= '0;
							bits_q    <= '0;
							padding_q <= 1'b0;
							final_q   <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							cnt_q <= {4'd0, cnt_q[2:0] + 3'd1};
						end
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-224 byte stream hasher testbench
// Feeds byte and end-of-message requests through the input handshake, keeps
// a behavioral SHA-224 of its own, and compares every digest word that leaves
// the output handshake against the digest computed for that message.
// ----------------------------------------------------------------------------
module tb_top
	import sha224_pkg::*;
();

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic byte_present = 1'b0;
	logic end_of_message = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	byte_req_t   pending_reqs[$];
	digest_out_t digest_words_due[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          stim_done = 1'b0;
	bit          quiet_tail = 1'b0;
	int unsigned hold_off_cycles = 0;

	// Predictor state.
	logic [7:0]  blk_bytes[64];
	int unsigned msg_fill;
	logic [63:0] msg_len_bits;
	logic [31:0] hash_state[8];

	sha224_byte_stream_hasher DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .byte_present(byte_present),
		.end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] round_const(int r);
		logic [31:0] tbl[64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return tbl[r];
	endfunction

	// Reload the SHA-224 starting chain value for a new message.
	task automatic restart_hash();
		logic [31:0] init[8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17,
			32'hf70e5939, 32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
		hash_state = init;
		msg_fill = 0;
		msg_len_bits = '0;
	endtask

	// One 64-round compression of the held block into the chain value.
	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = hash_state;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(r) + w[r];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
		msg_fill = 0;
	endtask

	// Apply one accepted request and queue any digest words it produces.
	task automatic hash_request(byte_req_t req);
		digest_out_t d;
		if (req.has_byte) begin
			blk_bytes[msg_fill] = req.data;
			msg_fill++;
			msg_len_bits += 64'd8;
			if (msg_fill == 64)
				compress_block();
		end
		if (req.eom) begin
			blk_bytes[msg_fill] = PadByte;
			msg_fill++;
			if (msg_fill > LenPos) begin
				while (msg_fill < 64) blk_bytes[msg_fill++] = 8'h00;
				compress_block();
			end
			while (msg_fill < LenPos) blk_bytes[msg_fill++] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk_bytes[LenPos + i] = msg_len_bits[63 - 8*i -: 8];
			compress_block();
			for (int i = 0; i < 7; i++) begin
				d.word = hash_state[i];
				d.idx = 3'(i);
				d.last = (i == 6);
				digest_words_due.push_back(d);
			end
			restart_hash();
		end
	endtask

	function automatic byte_req_t make_req(logic [7:0] b, logic hb, logic e);
		byte_req_t r;
		r.data = b; r.has_byte = hb; r.eom = e;
		return r;
	endfunction

	// Queue a message of n random bytes with random idle items among them, closing it with a random kind of end.
	task automatic queue_message(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				pending_reqs.push_back(make_req(8'($urandom), 1'b0, 1'b0));
			if (i == n - 1 && $urandom_range(0, 1))
				pending_reqs.push_back(make_req(8'($urandom), 1'b1, 1'b1));
			else
				pending_reqs.push_back(make_req(8'($urandom), 1'b1, 1'b0));
		end
		if (n == 0 || pending_reqs[$].eom == 1'b0)
			pending_reqs.push_back(make_req(8'($urandom), 1'b0, 1'b1));
	endtask

	// Stimulus: directed messages first, then random ones.
	initial begin
		int remaining;
		restart_hash();
		// Empty message, and an idle item before it.
		pending_reqs.push_back(make_req(8'hff, 1'b0, 1'b0));
		pending_reqs.push_back(make_req(8'hff, 1'b0, 1'b1));
		// Extreme byte values, last byte carried by the end request.
		pending_reqs.push_back(make_req(8'h00, 1'b1, 1'b0));
		pending_reqs.push_back(make_req(8'hff, 1'b1, 1'b1));
		pending_reqs.push_back(make_req(8'hff, 1'b1, 1'b1));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Padding split (56 bytes), 55 bytes, and exactly one block.
		queue_message(56);
		queue_message(55);
		queue_message(64);
		remaining = 40;
		while (remaining > 0) begin
			int n;
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
			if (n + 1 > remaining)
				n = remaining - 1;
			queue_message(n);
			remaining -= n + 1;
		end
		wait (pending_reqs.size() == 0);
		stim_done = 1'b1;
	end

	// Driver: offers requests with random idle bursts.
	always @(posedge clk) begin
		static int unsigned gap = 0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				hash_request({data_byte, byte_present, end_of_message});
				void'(pending_reqs.pop_front());
			end
			if (!(in_valid && !in_ready)) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					byte_req_t nxt;
					nxt = pending_reqs[0];
					in_valid <= 1'b1;
					data_byte <= nxt.data;
					byte_present <= nxt.has_byte;
					end_of_message <= nxt.eom;
					if (!quiet_tail && $urandom_range(0, 5) == 0)
						gap = $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
			quiet_tail <= pending_reqs.size() < 60;
		end
	end

	// Long receiver hold-off early in the run, so the input side backs up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cycle_count == 300)
				hold_off_cycles <= 600;
			else if (hold_off_cycles > 0)
				hold_off_cycles <= hold_off_cycles - 1;
		end
	end

	// Monitor: checks digest words and drives a stalling receiver.
	always @(posedge clk) begin
		static int unsigned stall = 0;
		digest_out_t exp_w;
		if (arst_n) begin
			cycle_count++;
			if (out_valid && out_ready) begin
				if (digest_words_due.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, digest_word);
					error_count++;
				end else begin
					exp_w = digest_words_due.pop_front();
					if (exp_w.word !== digest_word || exp_w.idx !== word_index
							|| exp_w.last !== last_word) begin
						$display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
							$time, exp_w.word, exp_w.idx, exp_w.last,
							digest_word, word_index, last_word);
						error_count++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 4) == 0)
					stall = $urandom_range(1, 10);
			end
		end
	end

	// End of run and timeout.
	initial begin
		wait (stim_done && digest_words_due.size() == 0 && !in_valid);
		repeat (200) @(posedge clk);
		if (error_count == 0 && digest_words_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		wait (cycle_count == 400000);
		$display("FAIL");
		$finish;
	end

endmodule
